FILE: rtl/core/fvn_pkg.sv
`default_nettype none
package fvn_pkg;

  localparam logic [31:0] MIX_K1    = 32'h7feb352d;
  localparam logic [31:0] MIX_K2    = 32'h846ca68b;
  localparam logic [31:0] HASH_CX   = 32'h9e3779b9;
  localparam logic [31:0] HASH_CY   = 32'h85ebca6b;
  localparam logic [15:0] AMP_START = 16'h8000;
  localparam int          SUM_W     = 36;
  localparam logic [16:0] NOISE_MAX = 17'h1ffff;

  localparam logic [7:0] REG_SEED    = 8'd0;
  localparam logic [7:0] REG_OCTAVES = 8'd1;
  localparam logic [7:0] REG_LACUN   = 8'd2;
  localparam logic [7:0] REG_GAIN    = 8'd3;

  typedef struct packed {
    logic [63:0]      cx;
    logic [63:0]      cy;
    logic [15:0]      amp;
    logic [31:0]      seed;
    logic [SUM_W-1:0] sum;
  } lane_t;

  typedef struct packed {
    logic [31:0] seed;
    logic [4:0]  octaves;
    logic [14:0] lacun;
    logic [15:0] gain;
  } fvn_cfg_t;

  function automatic logic [31:0] mix_a(input logic [31:0] v);
    mix_a = (v ^ (v >> 16)) * MIX_K1;
  endfunction

  function automatic logic [31:0] mix_b(input logic [31:0] p);
    mix_b = (p ^ (p >> 15)) * MIX_K2;
  endfunction

  function automatic logic [31:0] mix_c(input logic [31:0] q);
    mix_c = q ^ (q >> 16);
  endfunction

  function automatic logic [63:0] scale_lac(input logic [63:0] c, input logic [14:0] lac);
    logic [63:0] q;
    logic [26:0] rl;
    q  = {{12{c[63]}}, c[63:12]};
    rl = {15'd0, c[11:0]} * {12'd0, lac};
    scale_lac = q * {49'd0, lac} + {49'd0, rl[26:12]};
  endfunction

  function automatic logic [15:0] smooth_b(input logic [31:0] tt, input logic [15:0] t);
    logic [49:0] p;
    p = {18'd0, tt} * {32'd0, 18'd196608 - {1'b0, t, 1'b0}};
    smooth_b = p[47:32];
  endfunction

  function automatic logic [15:0] blend16(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] u);
    logic [33:0] p;
    p = {18'd0, a} * {17'd0, 17'h10000 - {1'b0, u}} + {18'd0, b} * {18'd0, u};
    blend16 = p[31:16];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/fvn_cell.sv
`default_nettype none
module fvn_cell import fvn_pkg::*; #(
  parameter int IDX       = 0,
  parameter int FRAC_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire fvn_cfg_t cfg,
  input  wire logic     in_vld,
  input  wire lane_t    in_lane,
  output logic          out_vld,
  output lane_t         out_lane
);

  logic [15:0] tx, ty;
  logic [31:0] ix, iy;
  logic        act;

  assign ix  = in_lane.cx[FRAC_BITS+31:FRAC_BITS];
  assign iy  = in_lane.cy[FRAC_BITS+31:FRAC_BITS];
  assign act = (5'(IDX) < cfg.octaves);

  if (FRAC_BITS >= 16) begin : g_frac_hi
    assign tx = in_lane.cx[FRAC_BITS-1 -: 16];
    assign ty = in_lane.cy[FRAC_BITS-1 -: 16];
  end else begin : g_frac_lo
    assign tx = {in_lane.cx[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
    assign ty = {in_lane.cy[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
  end

  logic [7:1] vld_r;
  logic [6:1] act_r;
  lane_t      lane_r [1:7];
  logic [15:0] amp_r [1:6];

  logic [3:0][31:0] pa_r, pb_r, ha_r, hb_r;
  logic [31:0] ttx_r, tty_r, sa_r, sb_r;
  logic [15:0] tx1_r, ty1_r, sx_r [2:4], sy_r [2:5];
  logic [15:0] nx0_r, nx1_r, nv_r;

  logic [3:0][31:0] hn;
  logic [31:0] mx0, mx1, my0, my1;

  assign mx0 = mix_c(pb_r[0]);
  assign mx1 = mix_c(pb_r[1]);
  assign my0 = mix_c(pb_r[2]);
  assign my1 = mix_c(pb_r[3]);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hn[k] = mix_c(hb_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act_r     <= {act_r[5:1], act};
      pa_r[0]   <= mix_a(ix + HASH_CX);
      pa_r[1]   <= mix_a(ix + 32'd1 + HASH_CX);
      pa_r[2]   <= mix_a(iy + HASH_CY);
      pa_r[3]   <= mix_a(iy + 32'd1 + HASH_CY);
      ttx_r     <= {16'd0, tx} * {16'd0, tx};
      tty_r     <= {16'd0, ty} * {16'd0, ty};
      tx1_r     <= tx;
      ty1_r     <= ty;
      sa_r      <= mix_a(in_lane.seed + HASH_CX + 32'(IDX));
      amp_r[1]  <= in_lane.amp;
      lane_r[1].cx   <= scale_lac(in_lane.cx, cfg.lacun);
      lane_r[1].cy   <= scale_lac(in_lane.cy, cfg.lacun);
      lane_r[1].amp  <= 16'(({16'd0, in_lane.amp} * {16'd0, cfg.gain}) >> 16);
      lane_r[1].seed <= in_lane.seed;
      lane_r[1].sum  <= in_lane.sum;

      for (int k = 0; k < 4; k++) begin
        pb_r[k] <= mix_b(pa_r[k]);
        hb_r[k] <= mix_b(ha_r[k]);
      end
      sx_r[2]  <= smooth_b(ttx_r, tx1_r);
      sy_r[2]  <= smooth_b(tty_r, ty1_r);
      sb_r     <= mix_b(sa_r);
      lane_r[2] <= lane_r[1];
      amp_r[2]  <= amp_r[1];

      ha_r[0] <= mix_a(lane_r[2].seed ^ mx0 ^ my0);
      ha_r[1] <= mix_a(lane_r[2].seed ^ mx1 ^ my0);
      ha_r[2] <= mix_a(lane_r[2].seed ^ mx0 ^ my1);
      ha_r[3] <= mix_a(lane_r[2].seed ^ mx1 ^ my1);
      sx_r[3] <= sx_r[2];
      sy_r[3] <= sy_r[2];
      lane_r[3].cx   <= lane_r[2].cx;
      lane_r[3].cy   <= lane_r[2].cy;
      lane_r[3].amp  <= lane_r[2].amp;
      lane_r[3].seed <= mix_c(sb_r);
      lane_r[3].sum  <= lane_r[2].sum;
      amp_r[3]  <= amp_r[2];

      sx_r[4]   <= sx_r[3];
      sy_r[4]   <= sy_r[3];
      lane_r[4] <= lane_r[3];
      amp_r[4]  <= amp_r[3];

      nx0_r     <= blend16(hn[0][15:0], hn[1][15:0], sx_r[4]);
      nx1_r     <= blend16(hn[2][15:0], hn[3][15:0], sx_r[4]);
      sy_r[5]   <= sy_r[4];
      lane_r[5] <= lane_r[4];
      amp_r[5]  <= amp_r[4];

      nv_r      <= blend16(nx0_r, nx1_r, sy_r[5]);
      lane_r[6] <= lane_r[5];
      amp_r[6]  <= amp_r[5];

      lane_r[7].cx   <= lane_r[6].cx;
      lane_r[7].cy   <= lane_r[6].cy;
      lane_r[7].amp  <= lane_r[6].amp;
      lane_r[7].seed <= lane_r[6].seed;
      if (act_r[6]) begin
        lane_r[7].sum <= lane_r[6].sum + {{(SUM_W-32){1'b0}}, {16'd0, nv_r} * {16'd0, amp_r[6]}};
      end else begin
        lane_r[7].sum <= lane_r[6].sum;
      end
    end
  end

  assign out_vld  = vld_r[7];
  assign out_lane = lane_r[7];

endmodule
`default_nettype wire

FILE: rtl/core/fbm_value_noise.sv
`default_nettype none
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | in_coord_x, in_coord_y (signed Q16.16)
// out     | output    | out_valid/out_stall | out_noise_value (Q1.16, saturated)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// One sample enters per cycle while in_stall is low; a result passes through
// 7*MAX_OCTAVES+1 register stages after its request is taken.
// Each octave cell is a 7-stage pipeline: four hash multiplies in series,
// two blend stages and the accumulate.
// Reset clears all valid bits and loads register defaults.
// A held result stalls the whole chain and the input together.
module fbm_value_noise import fvn_pkg::*; #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_coord_x,
  input  wire logic [31:0] in_coord_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      out_noise_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] seed_r;
  logic [3:0]  octaves_r;
  logic [14:0] lacun_r;
  logic [15:0] gain_r;
  fvn_cfg_t    cfg;
  logic        en;
  logic        out_valid_r;
  logic [16:0] noise_r;

  logic  [MAX_OCTAVES:0] vld;
  lane_t lane [0:MAX_OCTAVES];
  logic [63:0] ext_x, ext_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= 32'd0;
      octaves_r <= 4'd5;
      lacun_r   <= 15'd8397;
      gain_r    <= 16'd36045;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SEED:    seed_r    <= cfg_data;
        REG_OCTAVES: octaves_r <= cfg_data[3:0];
        REG_LACUN:   lacun_r   <= cfg_data[14:0];
        REG_GAIN:    gain_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.seed  = seed_r;
    cfg.lacun = lacun_r;
    cfg.gain  = gain_r;
    if (octaves_r == 4'd0) begin
      cfg.octaves = 5'd1;
    end else if ({1'b0, octaves_r} > 5'(MAX_OCTAVES)) begin
      cfg.octaves = 5'(MAX_OCTAVES);
    end else begin
      cfg.octaves = {1'b0, octaves_r};
    end
  end

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign ext_x = {{32{in_coord_x[31]}}, in_coord_x};
  assign ext_y = {{32{in_coord_y[31]}}, in_coord_y};

  if (FRAC_BITS >= 16) begin : g_load_hi
    assign lane[0].cx = ext_x << (FRAC_BITS - 16);
    assign lane[0].cy = ext_y << (FRAC_BITS - 16);
  end else begin : g_load_lo
    assign lane[0].cx = 64'($signed(ext_x) >>> (16 - FRAC_BITS));
    assign lane[0].cy = 64'($signed(ext_y) >>> (16 - FRAC_BITS));
  end

  assign lane[0].amp  = AMP_START;
  assign lane[0].seed = seed_r;
  assign lane[0].sum  = '0;
  assign vld[0]       = in_valid;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
    fvn_cell #(
      .IDX       (i),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cfg      (cfg),
      .in_vld   (vld[i]),
      .in_lane  (lane[i]),
      .out_vld  (vld[i+1]),
      .out_lane (lane[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[MAX_OCTAVES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (lane[MAX_OCTAVES].sum[SUM_W-1:16] > {{(SUM_W-33){1'b0}}, NOISE_MAX}) begin
        noise_r <= NOISE_MAX;
      end else begin
        noise_r <= lane[MAX_OCTAVES].sum[32:16];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = noise_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(vld[MAX_OCTAVES:1]))
    else $error("cell chain moved during stall");

  a_drop_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(!out_stall))
    else $error("result dropped without request taken");

endmodule
`default_nettype wire

FILE: tb/tb_fbm_value_noise.sv
module tb_fbm_value_noise;
  import fvn_pkg::*;

  localparam int MAX_OCT = 8;
  localparam int LATENCY = 7 * MAX_OCT + 1;
  localparam logic [7:0] REG_UNUSED = 8'd9;

  typedef struct {
    logic [31:0] cx;
    logic [31:0] cy;
  } sample_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_coord_x;
  logic [31:0] in_coord_y;
  logic        out_valid;
  logic        out_stall;
  logic [16:0] out_noise_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;

  fbm_value_noise DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_noise_value(out_noise_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [31:0] seed_reg;
  logic [3:0]  oct_reg;
  logic [14:0] lac_reg;
  logic [15:0] gain_reg;

  sample_t     pending_samples[$];
  logic [16:0] expected_noise[$];
  int          in_idle_pct;
  int          out_stall_pct;
  int          holdoff_cycles;
  int          mismatches;
  bit          failed;
  bit          in_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("tb_fbm_value_noise: FAIL");
    $finish;
  end

  function automatic logic [31:0] avalanche(input logic [31:0] v);
    logic [31:0] w;
    w = v ^ (v >> 16);
    w = w * 32'h7feb352d;
    w = w ^ (w >> 15);
    w = w * 32'h846ca68b;
    w = w ^ (w >> 16);
    return w;
  endfunction

  function automatic logic [15:0] corner_value(input logic [31:0] ix, input logic [31:0] iy,
                                               input logic [31:0] s);
    logic [31:0] h;
    h = s ^ avalanche(ix + 32'h9e3779b9) ^ avalanche(iy + 32'h85ebca6b);
    h = avalanche(h);
    return h[15:0];
  endfunction

  function automatic logic [63:0] smoothstep(input logic [63:0] t);
    return (t * t * (64'd196608 - 64'd2 * t)) >> 32;
  endfunction

  function automatic logic [63:0] lerp16(input logic [63:0] a, input logic [63:0] b,
                                         input logic [63:0] u);
    return (a * (64'd65536 - u) + b * u) >> 16;
  endfunction

  function automatic logic [63:0] grow_coord(input logic [63:0] c, input logic [63:0] lac);
    logic [63:0] q;
    q = $unsigned($signed(c) >>> 12);
    return q * lac + (((c & 64'hfff) * lac) >> 12);
  endfunction

  function automatic logic [16:0] fbm_noise(input logic [31:0] x, input logic [31:0] y);
    logic [63:0] cx, cy, amp, total, u, v, nx0, nx1, res;
    logic [31:0] s, ix, iy;
    int n;
    cx = {{32{x[31]}}, x};
    cy = {{32{y[31]}}, y};
    amp = 64'd32768;
    total = 0;
    s = seed_reg;
    n = int'(oct_reg);
    if (n < 1) n = 1;
    if (n > MAX_OCT) n = MAX_OCT;
    for (int i = 0; i < n; i++) begin
      ix = cx[47:16];
      iy = cy[47:16];
      u = smoothstep({48'd0, cx[15:0]});
      v = smoothstep({48'd0, cy[15:0]});
      nx0 = lerp16({48'd0, corner_value(ix, iy, s)},
                   {48'd0, corner_value(ix + 32'd1, iy, s)}, u);
      nx1 = lerp16({48'd0, corner_value(ix, iy + 32'd1, s)},
                   {48'd0, corner_value(ix + 32'd1, iy + 32'd1, s)}, u);
      total += lerp16(nx0, nx1, v) * amp;
      cx = grow_coord(cx, {49'd0, lac_reg});
      cy = grow_coord(cy, {49'd0, lac_reg});
      amp = (amp * {48'd0, gain_reg}) >> 16;
      s = avalanche(s + 32'h9e3779b9 + 32'(i));
    end
    res = total >> 16;
    if (res > 64'd131071) res = 64'd131071;
    return res[16:0];
  endfunction

  function automatic void queue_expected(input logic [16:0] val);
    expected_noise = {expected_noise, val};
  endfunction

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_taken) begin
      if (pending_samples.size() > 0 && $urandom_range(99, 0) >= in_idle_pct) begin
        in_coord_x <= pending_samples[0].cx;
        in_coord_y <= pending_samples[0].cy;
        queue_expected(fbm_noise(pending_samples[0].cx, pending_samples[0].cy));
        void'(pending_samples.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && pending_samples.size() > 0 &&
                 $urandom_range(99, 0) >= in_idle_pct) begin
      in_valid <= 1'b1;
      in_coord_x <= pending_samples[0].cx;
      in_coord_y <= pending_samples[0].cy;
      queue_expected(fbm_noise(pending_samples[0].cx, pending_samples[0].cy));
      void'(pending_samples.pop_front());
    end
  end

  always @(negedge clk) begin
    if (holdoff_cycles > 0) begin
      out_stall <= 1'b1;
      holdoff_cycles <= holdoff_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_noise.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0h", out_noise_value);
      end else begin
        if (out_noise_value !== expected_noise[0]) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("noise mismatch: expected %0h actual %0h",
                     expected_noise[0], out_noise_value);
        end
        void'(expected_noise.pop_front());
      end
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SEED:    seed_reg = data;
      REG_OCTAVES: oct_reg = data[3:0];
      REG_LACUN:   lac_reg = data[14:0];
      REG_GAIN:    gain_reg = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_sample(input logic [31:0] x, input logic [31:0] y);
    sample_t smp;
    smp.cx = x;
    smp.cy = y;
    pending_samples = {pending_samples, smp};
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while ((pending_samples.size() > 0 || in_valid || expected_noise.size() > 0) &&
           guard < 5000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic add_random(input int count);
    logic [31:0] x, y;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3, 0))
        0: begin x = $urandom(); y = $urandom(); end
        1: begin
          x = $urandom_range(32'h00ffffff, 0) - 32'h00800000;
          y = $urandom_range(32'h00ffffff, 0) - 32'h00800000;
        end
        2: begin x = {2'($urandom_range(3, 0)), 14'd0, 16'($urandom_range(65535, 0))};
                 y = {2'($urandom_range(3, 0)), 14'd0, 16'($urandom_range(65535, 0))}; end
        default: begin x = $urandom() | 32'h80000000; y = $urandom() & 32'h7fffffff; end
      endcase
      add_sample(x, y);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_coord_x = '0;
    in_coord_y = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    holdoff_cycles = 0;
    mismatches = 0;
    failed = 1'b0;
    seed_reg = 32'd0;
    oct_reg = 4'd5;
    lac_reg = 15'd8397;
    gain_reg = 16'd36045;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_sample(32'h0, 32'h0);
    add_sample(32'h7fffffff, 32'h7fffffff);
    add_sample(32'h80000000, 32'h80000000);
    add_sample(32'h80000000, 32'h7fffffff);
    add_sample(32'hffffffff, 32'h00000001);
    add_sample(32'h0000ffff, 32'hffff0000);
    add_sample(32'h00008000, 32'h00018000);
    add_sample(32'h55555555, 32'haaaaaaaa);
    drain();

    write_reg(REG_SEED, 32'hffffffff);
    write_reg(REG_OCTAVES, 32'd0);
    write_reg(REG_LACUN, 32'd4096);
    write_reg(REG_GAIN, 32'd65535);
    write_reg(REG_UNUSED, 32'h12345678);
    add_sample(32'h7fffffff, 32'h80000000);
    add_sample(32'h12345678, 32'h9abcdef0);
    add_random(4);
    drain();

    write_reg(REG_OCTAVES, 32'd15);
    write_reg(REG_LACUN, 32'd32767);
    write_reg(REG_GAIN, 32'd65535);
    add_sample(32'h7fffffff, 32'h7fffffff);
    add_sample(32'h80000000, 32'h00000000);
    add_random(4);
    drain();

    write_reg(REG_OCTAVES, 32'd8);
    write_reg(REG_LACUN, 32'd4095);
    write_reg(REG_GAIN, 32'd0);
    add_random(4);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_SEED, $urandom());
      write_reg(REG_OCTAVES, $urandom_range(15, 0));
      write_reg(REG_LACUN, $urandom_range(32767, 0));
      write_reg(REG_GAIN, $urandom_range(65535, 0));
      case (phase % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 81; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 81; end
        default: begin in_idle_pct = 14; out_stall_pct = 14; end
      endcase
      if (phase == 4) holdoff_cycles = 3 * LATENCY;
      add_random(215);
      drain();
    end

    if (!failed && expected_noise.size() == 0 && pending_samples.size() == 0) begin
      $display("tb_fbm_value_noise: PASS");
    end else begin
      $display("tb_fbm_value_noise: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/fvn_pkg.sv
rtl/core/fvn_cell.sv
rtl/core/fbm_value_noise.sv
tb/tb_fbm_value_noise.sv
